@@ src/assert_macros.svh @@
// assertion macros shared by the flattener rtl
// depends on nothing; defining NO_ASSERTIONS compiles every use to nothing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define GLF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// expression must never be true outside reset
`define GLF_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");

`else

`define GLF_ASSERT(label, clk, rst_n, prop)
`define GLF_NEVER(label, clk, rst_n, expr)

`endif

`endif

@@ src/glf_pkg.sv @@
// shared types, constants and bezier coefficient functions of the flattener
// used by every module of the block; depends on nothing
`default_nettype none

package glf_pkg;

    // chords per quadratic curve and derived divisor
    localparam int SEGMENTS = 5;
    localparam int SEG_SQ   = SEGMENTS * SEGMENTS;
    localparam int CLOG_D   = $clog2(SEG_SQ);

    // field widths
    localparam int PT_W    = 16;
    localparam int COORD_W = 48;
    localparam int SCALE_W = 32;
    localparam int KIND_W  = 3;

    // derived arithmetic widths
    localparam int J_W    = $clog2(SEGMENTS + 1);
    localparam int COEF_W = $clog2(SEG_SQ + 1);
    localparam int N_W    = PT_W + CLOG_D + 1;
    localparam int REM_W  = $clog2(SEG_SQ + 1);

    // scale register reset: 1.0 with 24 fractional bits
    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0100_0000;

    // vertex queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // register stages inside the coordinate scaler
    localparam int SCALER_STAGES = 5;

    // vertex kind codes
    localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MOVE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LINE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CURVE = 3'd3;

    typedef enum logic [1:0] {
        OP_MOVE,
        OP_LINE,
        OP_CURVE
    } t_op;

    typedef struct packed {
        logic [KIND_W-1:0]      vertex_kind;
        logic signed [PT_W-1:0] point_x;
        logic signed [PT_W-1:0] point_y;
        logic signed [PT_W-1:0] control_x;
        logic signed [PT_W-1:0] control_y;
        logic                   glyph_start;
    } t_vertex;

    typedef struct packed {
        logic signed [COORD_W-1:0] seg_start_x;
        logic signed [COORD_W-1:0] seg_start_y;
        logic signed [COORD_W-1:0] seg_end_x;
        logic signed [COORD_W-1:0] seg_end_y;
        logic                      last_segment;
    } t_segment;

    // classified vertex handed from front to back
    typedef struct packed {
        t_op                    op;
        logic                   glyph_start;
        logic signed [PT_W-1:0] prior_x;
        logic signed [PT_W-1:0] prior_y;
        logic signed [PT_W-1:0] control_x;
        logic signed [PT_W-1:0] control_y;
        logic signed [PT_W-1:0] point_x;
        logic signed [PT_W-1:0] point_y;
    } t_cmd;

    // per-step control carried alongside the scaler pipeline
    typedef struct packed {
        logic valid;
        logic emit;
        logic last;
        logic clr;
    } t_step_tag;

    // bernstein weights times SEGMENTS^2 at step j
    function automatic logic [COEF_W-1:0] bez_c0(input logic [J_W-1:0] j);
        int k;
        k = SEGMENTS - int'(j);
        return COEF_W'(k * k);
    endfunction

    function automatic logic [COEF_W-1:0] bez_c1(input logic [J_W-1:0] j);
        int k;
        k = SEGMENTS - int'(j);
        return COEF_W'(2 * int'(j) * k);
    endfunction

    function automatic logic [COEF_W-1:0] bez_c2(input logic [J_W-1:0] j);
        int k;
        k = int'(j);
        return COEF_W'(k * k);
    endfunction

endpackage

`default_nettype wire

@@ src/glf_front.sv @@
// front end: accepts vertices, classifies the kind and attaches the prior vertex
// depends on glf_pkg; feeds glf_queue
`default_nettype none

module glf_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vtx_valid,
    output logic             o_vtx_ready,
    input  glf_pkg::t_vertex i_vtx,
    input  logic             i_full,
    output logic             o_push,
    output glf_pkg::t_cmd    o_cmd
);
    import glf_pkg::*;

    logic signed [PT_W-1:0] r_prior_x;
    logic signed [PT_W-1:0] r_prior_y;
    t_op                    op;

    // handshake: take a vertex whenever the queue has room
    assign o_vtx_ready = !i_full;
    assign o_push      = i_vtx_valid && !i_full;

    // kind decode
    always_comb begin
        unique case (i_vtx.vertex_kind) inside
            KIND_NONE, KIND_MOVE: op = OP_MOVE;
            KIND_CURVE:           op = OP_CURVE;
            default:              op = OP_LINE;
        endcase
    end

    // command build, glyph start clears the prior vertex
    always_comb begin
        o_cmd.op          = op;
        o_cmd.glyph_start = i_vtx.glyph_start;
        o_cmd.prior_x     = i_vtx.glyph_start ? '0 : r_prior_x;
        o_cmd.prior_y     = i_vtx.glyph_start ? '0 : r_prior_y;
        o_cmd.control_x   = i_vtx.control_x;
        o_cmd.control_y   = i_vtx.control_y;
        o_cmd.point_x     = i_vtx.point_x;
        o_cmd.point_y     = i_vtx.point_y;
    end

    // every accepted vertex becomes the prior one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior_x <= '0;
            r_prior_y <= '0;
        end else if (o_push) begin
            r_prior_x <= i_vtx.point_x;
            r_prior_y <= i_vtx.point_y;
        end
    end

endmodule

`default_nettype wire

@@ src/glf_queue.sv @@
// small fifo of classified vertices between front and back
// depends on glf_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module glf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  glf_pkg::t_cmd i_push_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_pop_valid,
    output glf_pkg::t_cmd o_pop_data
);
    import glf_pkg::*;

    localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [QP_W-1:0] r_wr_ptr;
    logic [QP_W-1:0] r_rd_ptr;
    logic [QC_W-1:0] r_count;
    logic [QP_W-1:0] n_wr_ptr;
    logic [QP_W-1:0] n_rd_ptr;
    logic [QC_W-1:0] n_count;

    assign o_full      = (r_count == QC_W'(QUEUE_DEPTH));
    assign o_pop_valid = (r_count != '0);
    assign o_pop_data  = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    `GLF_NEVER(a_no_push_when_full, i_clk, i_rst_n, i_push && o_full)
    `GLF_NEVER(a_no_pop_when_empty, i_clk, i_rst_n, i_pop && !o_pop_valid)

endmodule

`default_nettype wire

@@ src/glf_scaler.sv @@
// five-stage coordinate unit: bernstein numerator, exact floor(n*scale/SEGMENTS^2)
// depends on glf_pkg; two copies sit in glf_back, one per axis
`default_nettype none

module glf_scaler (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [glf_pkg::COEF_W-1:0]         i_c0,
    input  logic [glf_pkg::COEF_W-1:0]         i_c1,
    input  logic [glf_pkg::COEF_W-1:0]         i_c2,
    input  logic signed [glf_pkg::PT_W-1:0]    i_p0,
    input  logic signed [glf_pkg::PT_W-1:0]    i_cp,
    input  logic signed [glf_pkg::PT_W-1:0]    i_p2,
    input  logic [glf_pkg::SCALE_W-1:0]        i_scale,
    input  logic [glf_pkg::SCALE_W-1:0]        i_scale_div,
    input  logic [glf_pkg::REM_W-1:0]          i_scale_rem,
    output logic [glf_pkg::COORD_W-1:0]        o_coord
);
    import glf_pkg::*;

    // numerator / SEGMENTS^2 by reciprocal, numerator offset to be non-negative
    localparam int QK   = N_W + CLOG_D;
    localparam int QM_W = N_W + 1;
    localparam int QP_W = N_W + QM_W;
    localparam logic [63:0] QM_64 = ((64'd1 << QK) + 64'(SEG_SQ) - 64'd1) / 64'(SEG_SQ);
    localparam logic [QM_W-1:0] QM = QM_64[QM_W-1:0];
    localparam int OFFS = SEG_SQ * (1 << (PT_W - 1));

    // remainder product / SEGMENTS^2 by reciprocal
    localparam int RB_W   = 2 * REM_W;
    localparam int RB_K   = RB_W + CLOG_D;
    localparam int RB_M_W = RB_W + 1;
    localparam int RBP_W  = RB_W + RB_M_W;
    localparam logic [63:0] RB_M_64 = ((64'd1 << RB_K) + 64'(SEG_SQ) - 64'd1) / 64'(SEG_SQ);
    localparam logic [RB_M_W-1:0] RB_M = RB_M_64[RB_M_W-1:0];

    localparam int RA_W = REM_W + SCALE_W;

    logic signed [N_W-1:0]    r_num;
    logic signed [N_W-1:0]    r_num2;
    logic [PT_W-1:0]          r_qu;
    logic signed [PT_W-1:0]   r_q;
    logic [REM_W-1:0]         r_rem;
    logic [COORD_W-1:0]       r_qs;
    logic [RA_W-1:0]          r_ra;
    logic [RB_W-1:0]          r_rb;
    logic [COORD_W-1:0]       r_coord;

    logic signed [N_W-1:0]    n_num;
    logic [N_W-1:0]           u;
    logic [QP_W-1:0]          qprod;
    logic signed [PT_W-1:0]   q;
    logic signed [N_W-1:0]    dq;
    logic signed [N_W-1:0]    rem_full;
    logic [RBP_W-1:0]         rbp;
    logic [REM_W-1:0]         rbd;

    // stage 1: numerator from the three weighted points
    assign n_num = N_W'($signed({1'b0, i_c0})) * N_W'(i_p0)
                 + N_W'($signed({1'b0, i_c1})) * N_W'(i_cp)
                 + N_W'($signed({1'b0, i_c2})) * N_W'(i_p2);

    // stage 2: quotient of the offset numerator
    assign u     = N_W'(r_num + N_W'(OFFS));
    assign qprod = QP_W'(u) * QP_W'(QM);

    // stage 3: remove the offset (flip msb) and form the remainder
    assign q        = $signed({~r_qu[PT_W-1], r_qu[PT_W-2:0]});
    assign dq       = N_W'(SEG_SQ) * N_W'(q);
    assign rem_full = r_num2 - dq;

    // stage 5: small remainder term
    assign rbp = RBP_W'(r_rb) * RBP_W'(RB_M);
    assign rbd = rbp[RB_K +: REM_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num   <= n_num;
            r_num2  <= r_num;
            r_qu    <= qprod[QK +: PT_W];
            r_q     <= q;
            r_rem   <= rem_full[REM_W-1:0];
            r_qs    <= COORD_W'(COORD_W'(r_q) * COORD_W'($signed({1'b0, i_scale})));
            r_ra    <= RA_W'(r_rem) * RA_W'(i_scale_div);
            r_rb    <= RB_W'(r_rem) * RB_W'(i_scale_rem);
            r_coord <= r_qs + COORD_W'(r_ra) + COORD_W'(rbd);
        end
    end

    assign o_coord = r_coord;

endmodule

`default_nettype wire

@@ src/glf_back.sv @@
// back end: step sequencer over chords, two coordinate scalers, pen and output register
// depends on glf_pkg, glf_scaler and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module glf_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [glf_pkg::SCALE_W-1:0] i_cfg_wr_data,
    input  logic                        i_cmd_valid,
    output logic                        o_cmd_pop,
    input  glf_pkg::t_cmd               i_cmd,
    output logic                        o_seg_valid,
    input  logic                        i_seg_ready,
    output glf_pkg::t_segment           o_seg
);
    import glf_pkg::*;

    // scale / SEGMENTS^2 by reciprocal
    localparam int SC_SHIFT   = SCALE_W + CLOG_D;
    localparam int SC_RECIP_W = SCALE_W + 1;
    localparam int SC_PROD_W  = SC_SHIFT + SCALE_W;
    localparam logic [63:0] SC_RECIP_64 =
        ((64'd1 << SC_SHIFT) + 64'(SEG_SQ) - 64'd1) / 64'(SEG_SQ);
    localparam logic [SC_RECIP_W-1:0] SC_RECIP = SC_RECIP_64[SC_RECIP_W-1:0];

    logic [SCALE_W-1:0]   r_scale;
    logic [SCALE_W-1:0]   r_scale_div;
    logic [REM_W-1:0]     r_scale_rem;
    logic [SC_PROD_W-1:0] sc_prod;
    logic [SCALE_W-1:0]   sc_back;
    logic [SCALE_W-1:0]   sc_rem_full;

    logic                 r_have;
    t_cmd                 r_cmd;
    logic [J_W-1:0]       r_j;
    logic                 r_first;
    t_step_tag            r_tag [SCALER_STAGES];
    t_step_tag            issue_tag;
    t_step_tag            tag_out;

    logic [COORD_W-1:0]   r_pen_x;
    logic [COORD_W-1:0]   r_pen_y;
    logic                 r_out_valid;
    t_segment             r_seg;

    logic                 adv;
    logic                 last_step;
    logic [COEF_W-1:0]    c0;
    logic [COEF_W-1:0]    c1;
    logic [COEF_W-1:0]    c2;
    logic [COORD_W-1:0]   coord_x;
    logic [COORD_W-1:0]   coord_y;

    // scale register and its quotient and remainder by SEGMENTS^2
    assign sc_prod     = SC_PROD_W'(r_scale) * SC_PROD_W'(SC_RECIP);
    assign sc_back     = SCALE_W'(SCALE_W'(SEG_SQ) * r_scale_div);
    assign sc_rem_full = r_scale - sc_back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg_wr_en) begin
            r_scale <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scale_div <= sc_prod[SC_SHIFT +: SCALE_W];
        r_scale_rem <= sc_rem_full[REM_W-1:0];
    end

    // the whole back pipeline moves when the output register can take a beat
    assign adv       = !r_out_valid || i_seg_ready;
    assign last_step = (r_j == J_W'(SEGMENTS));
    assign o_cmd_pop = adv && i_cmd_valid && (!r_have || last_step);

    // step sequencer: curves walk j = 1..SEGMENTS, others issue one step at j = SEGMENTS
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have  <= 1'b0;
            r_j     <= '0;
            r_first <= 1'b0;
        end else if (adv) begin
            if (r_have && !last_step) begin
                r_j     <= r_j + 1'b1;
                r_first <= 1'b0;
            end else if (o_cmd_pop) begin
                r_have  <= 1'b1;
                r_j     <= (i_cmd.op == OP_CURVE) ? J_W'(1) : J_W'(SEGMENTS);
                r_first <= 1'b1;
            end else begin
                r_have  <= 1'b0;
                r_first <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
    end

    // step controls and weights
    always_comb begin
        issue_tag.valid = r_have;
        issue_tag.emit  = (r_cmd.op != OP_MOVE);
        issue_tag.last  = last_step;
        issue_tag.clr   = r_cmd.glyph_start && r_first;
    end

    assign c0 = bez_c0(r_j);
    assign c1 = bez_c1(r_j);
    assign c2 = bez_c2(r_j);

    // tags follow the scaler stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SCALER_STAGES; i++) begin
                r_tag[i] <= '0;
            end
        end else if (adv) begin
            r_tag[0] <= issue_tag;
            for (int i = 1; i < SCALER_STAGES; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
        end
    end

    assign tag_out = r_tag[SCALER_STAGES-1];

    glf_scaler u_scaler_x (
        .i_clk       (i_clk),
        .i_en        (adv),
        .i_c0        (c0),
        .i_c1        (c1),
        .i_c2        (c2),
        .i_p0        (r_cmd.prior_x),
        .i_cp        (r_cmd.control_x),
        .i_p2        (r_cmd.point_x),
        .i_scale     (r_scale),
        .i_scale_div (r_scale_div),
        .i_scale_rem (r_scale_rem),
        .o_coord     (coord_x)
    );

    glf_scaler u_scaler_y (
        .i_clk       (i_clk),
        .i_en        (adv),
        .i_c0        (c0),
        .i_c1        (c1),
        .i_c2        (c2),
        .i_p0        (r_cmd.prior_y),
        .i_cp        (r_cmd.control_y),
        .i_p2        (r_cmd.point_y),
        .i_scale     (r_scale),
        .i_scale_div (r_scale_div),
        .i_scale_rem (r_scale_rem),
        .o_coord     (coord_y)
    );

    // pen and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x     <= '0;
            r_pen_y     <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= tag_out.valid && tag_out.emit;
            if (tag_out.valid) begin
                r_pen_x <= coord_x;
                r_pen_y <= coord_y;
            end
        end
    end

    // output beat payload, start is the pen unless the glyph restarts here
    always_ff @(posedge i_clk) begin
        if (adv && tag_out.valid && tag_out.emit) begin
            r_seg.seg_start_x  <= tag_out.clr ? '0 : r_pen_x;
            r_seg.seg_start_y  <= tag_out.clr ? '0 : r_pen_y;
            r_seg.seg_end_x    <= coord_x;
            r_seg.seg_end_y    <= coord_y;
            r_seg.last_segment <= tag_out.last;
        end
    end

    assign o_seg_valid = r_out_valid;
    assign o_seg       = r_seg;

    `GLF_ASSERT(a_single_step_kinds, i_clk, i_rst_n, (r_have && r_cmd.op != OP_CURVE) |-> last_step)
    `GLF_ASSERT(a_step_in_range, i_clk, i_rst_n, r_have |-> (r_j != '0 && r_j <= J_W'(SEGMENTS)))
    `GLF_ASSERT(a_curve_steps_advance, i_clk, i_rst_n, (r_have && !last_step && adv) |=> (r_have && r_j == $past(r_j) + J_W'(1)))
    `GLF_ASSERT(a_curve_starts_at_one, i_clk, i_rst_n, (r_have && r_first && r_cmd.op == OP_CURVE) |-> (r_j == J_W'(1)))

endmodule

`default_nettype wire

@@ src/glyph_outline_flattener.sv @@
// top level of the glyph outline flattener: front, vertex queue and back
// depends on glf_pkg, glf_front, glf_queue and glf_back
//
// channel   direction  handshake                     payload
// vertex    in         i_vtx_valid / o_vtx_ready     i_vtx (t_vertex)
// segment   out        o_seg_valid / i_seg_ready     o_seg (t_segment)
// config    in         i_cfg_wr_en, no wait          i_cfg_wr_data (scale_factor)
//
// the back step sequencer issues one chord per cycle while the output is not stalled: a curve vertex
// walks j = 1..SEGMENTS, any other vertex issues a single step at j = SEGMENTS
// a segment's vertex passes the queue, the step registers, the scaler stages and the output register
// a stalled segment beat freezes the back pipeline; the 2-entry queue lets the front take vertices until it is full
// reset is synchronous: pen, prior vertex, queue and scale (1.0) are set directly, no clearing pass
`default_nettype none

module glyph_outline_flattener (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vtx_valid,
    output logic                        o_vtx_ready,
    input  glf_pkg::t_vertex            i_vtx,
    output logic                        o_seg_valid,
    input  logic                        i_seg_ready,
    output glf_pkg::t_segment           o_seg,
    input  logic                        i_cfg_wr_en,
    input  logic [glf_pkg::SCALE_W-1:0] i_cfg_wr_data
);
    import glf_pkg::*;

    logic full;
    logic push;
    t_cmd push_cmd;
    logic pop;
    logic pop_valid;
    t_cmd pop_cmd;

    // classify incoming vertices
    glf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vtx_valid (i_vtx_valid),
        .o_vtx_ready (o_vtx_ready),
        .i_vtx       (i_vtx),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // decoupling queue
    glf_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_cmd),
        .o_full      (full),
        .i_pop       (pop),
        .o_pop_valid (pop_valid),
        .o_pop_data  (pop_cmd)
    );

    // chord generation and scaling
    glf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd_valid   (pop_valid),
        .o_cmd_pop     (pop),
        .i_cmd         (pop_cmd),
        .o_seg_valid   (o_seg_valid),
        .i_seg_ready   (i_seg_ready),
        .o_seg         (o_seg)
    );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// self-checking testbench for glyph_outline_flattener: directed table, then random glyphs
// depends on glf_pkg and the flattener rtl; predicts every segment beat in sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import glf_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS   = 83;
    localparam int N_DIRECTED    = 21;

    typedef enum logic [1:0] {
        ROW_VERTEX,
        ROW_CHECKED,
        ROW_SCALE
    } t_row_kind;

    typedef struct packed {
        t_row_kind            what;
        logic [SCALE_W-1:0]   scale;
        t_vertex              vtx;
        t_segment             seg;
    } t_stim_row;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               vtx_valid = 1'b0;
    logic               vtx_ready;
    t_vertex            vtx_beat = '0;
    logic               seg_valid;
    logic               seg_ready = 1'b0;
    t_segment           seg_beat;
    logic               cfg_wr_en = 1'b0;
    logic [SCALE_W-1:0] cfg_wr_data = '0;

    // predictor state
    longint             cursor_x = 0;
    longint             cursor_y = 0;
    longint             last_pt_x = 0;
    longint             last_pt_y = 0;
    logic [SCALE_W-1:0] scale_now = SCALE_RESET;
    t_segment           expected_segments [$];

    int                 gap_pct = 0;
    int                 stall_pct = 0;
    int                 fail_count = 0;
    int                 vertices_sent = 0;
    int                 segments_checked = 0;
    int                 scale_writes = 0;
    int                 cycle_count = 0;
    t_stim_row          directed [N_DIRECTED];

    glyph_outline_flattener i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_vtx_valid   (vtx_valid),
        .o_vtx_ready   (vtx_ready),
        .i_vtx         (vtx_beat),
        .o_seg_valid   (seg_valid),
        .i_seg_ready   (seg_ready),
        .o_seg         (seg_beat),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    // clock
    initial begin
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("glyph_outline_flattener test failed");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge clk) begin
        seg_ready <= ($urandom_range(99) >= stall_pct);
    end

    // floor(num * scale / SEGMENTS^2), all in 64 bits
    function automatic longint scaled_coord(input longint num);
        longint prod;
        longint q;
        prod = num * longint'({32'b0, scale_now});
        q = prod / SEG_SQ;
        if ((prod % SEG_SQ) != 0 && prod < 0)
            q -= 1;
        return q;
    endfunction

    // work out the segments one vertex causes and advance the pen
    function automatic void flatten_vertex(input t_vertex v);
        longint   px, py, cx, cy, ex, ey, qx, qy;
        t_segment seg;
        if (v.glyph_start) begin
            cursor_x = 0;
            cursor_y = 0;
            last_pt_x = 0;
            last_pt_y = 0;
        end
        px = signed'(v.point_x);
        py = signed'(v.point_y);
        cx = signed'(v.control_x);
        cy = signed'(v.control_y);
        ex = scaled_coord(SEG_SQ * px);
        ey = scaled_coord(SEG_SQ * py);
        if (v.vertex_kind == KIND_CURVE) begin
            // chords at t = j / SEGMENTS from the prior vertex through the control point
            for (int j = 1; j <= SEGMENTS; j++) begin
                qx = scaled_coord((SEGMENTS - j) * (SEGMENTS - j) * last_pt_x
                                  + 2 * j * (SEGMENTS - j) * cx + j * j * px);
                qy = scaled_coord((SEGMENTS - j) * (SEGMENTS - j) * last_pt_y
                                  + 2 * j * (SEGMENTS - j) * cy + j * j * py);
                seg = '{cursor_x[COORD_W-1:0], cursor_y[COORD_W-1:0],
                        qx[COORD_W-1:0], qy[COORD_W-1:0], (j == SEGMENTS)};
                expected_segments.push_back(seg);
                cursor_x = qx;
                cursor_y = qy;
            end
        end else if (v.vertex_kind > KIND_MOVE) begin
            // line, and every unknown kind above a curve
            seg = '{cursor_x[COORD_W-1:0], cursor_y[COORD_W-1:0],
                    ex[COORD_W-1:0], ey[COORD_W-1:0], 1'b1};
            expected_segments.push_back(seg);
        end
        cursor_x = ex;
        cursor_y = ey;
        last_pt_x = px;
        last_pt_y = py;
    endfunction

    function automatic void check_field(input string name, input logic [COORD_W-1:0] want,
                                        input logic [COORD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endfunction

    // segment checker, sampled mid-cycle where everything is settled
    always @(negedge clk) begin
        t_segment want;
        if (rst_n && seg_valid && seg_ready) begin
            if (expected_segments.size() == 0) begin
                $error("segment beat with nothing expected: %h", seg_beat);
                fail_count++;
            end else begin
                want = expected_segments.pop_front();
                check_field("seg_start_x", want.seg_start_x, seg_beat.seg_start_x);
                check_field("seg_start_y", want.seg_start_y, seg_beat.seg_start_y);
                check_field("seg_end_x", want.seg_end_x, seg_beat.seg_end_x);
                check_field("seg_end_y", want.seg_end_y, seg_beat.seg_end_y);
                check_field("last_segment", COORD_W'(want.last_segment),
                            COORD_W'(seg_beat.last_segment));
                segments_checked++;
            end
        end
    end

    function automatic t_vertex make_vertex(input logic [KIND_W-1:0] kind, input int x,
                                            input int y, input int cx, input int cy,
                                            input bit gs);
        return '{kind, PT_W'(x), PT_W'(y), PT_W'(cx), PT_W'(cy), gs};
    endfunction

    function automatic t_stim_row vertex_row(input logic [KIND_W-1:0] kind, input int x,
                                             input int y, input int cx, input int cy,
                                             input bit gs);
        return '{ROW_VERTEX, '0, make_vertex(kind, x, y, cx, cy, gs), '0};
    endfunction

    // single-segment row with its result written out
    function automatic t_stim_row checked_row(input logic [KIND_W-1:0] kind, input int x,
                                              input int y, input bit gs,
                                              input logic [COORD_W-1:0] sx,
                                              input logic [COORD_W-1:0] sy,
                                              input logic [COORD_W-1:0] ex,
                                              input logic [COORD_W-1:0] ey);
        return '{ROW_CHECKED, '0, make_vertex(kind, x, y, 0, 0, gs),
                 '{sx, sy, ex, ey, 1'b1}};
    endfunction

    function automatic t_stim_row scale_row(input logic [SCALE_W-1:0] s);
        return '{ROW_SCALE, s, '0, '0};
    endfunction

    // coordinates lean on the extremes now and then
    function automatic int random_coord();
        case ($urandom_range(9))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            4: return $urandom_range(64) - 32;
            default: return int'(signed'(16'($urandom)));
        endcase
    endfunction

    // glyphs open with a move; a few beats are noise with any kind and flag
    function automatic t_vertex random_vertex(input bit first);
        int                r;
        logic [KIND_W-1:0] kind;
        bit                gs;
        r = $urandom_range(99);
        gs = 1'b0;
        if (first) begin
            kind = KIND_MOVE;
            gs = ($urandom_range(9) != 0);
        end else if (r < 12) begin
            kind = KIND_W'($urandom_range(7));
            gs = $urandom_range(1);
        end else if (r < 55) begin
            kind = KIND_CURVE;
        end else begin
            kind = KIND_LINE;
        end
        return make_vertex(kind, random_coord(), random_coord(), random_coord(),
                           random_coord(), gs);
    endfunction

    // one vertex beat with random idle ahead of it; predicts at the accepting edge
    task automatic send_vertex(input t_vertex v);
        while ($urandom_range(99) < gap_pct) begin
            vtx_valid <= 1'b0;
            @(posedge clk);
        end
        vtx_valid <= 1'b1;
        vtx_beat <= v;
        do @(negedge clk); while (!vtx_ready);
        @(posedge clk);
        flatten_vertex(v);
        vertices_sent++;
    endtask

    // stop sending until all segments are out, then let the pipeline empty
    task automatic wait_drain();
        vtx_valid <= 1'b0;
        while (expected_segments.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] s);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= s;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        scale_now = s;
        scale_writes++;
    endtask

    // main sequence
    initial begin
        int            glyph_left;
        bit            first;
        logic [SCALE_W-1:0] phase_scale;

        // rows before the first scale row run at the reset scale of 1.0
        directed = '{
            checked_row(KIND_LINE, 32767, -32768, 1'b1, 48'h0, 48'h0,
                        48'h007F_FF00_0000, 48'hFF80_0000_0000),
            checked_row(3'd7, -32768, 32767, 1'b0,
                        48'h007F_FF00_0000, 48'hFF80_0000_0000,
                        48'hFF80_0000_0000, 48'h007F_FF00_0000),
            vertex_row(KIND_MOVE, 5, 5, 0, 0, 1'b0),
            vertex_row(KIND_NONE, 1, 1, 0, 0, 1'b0),
            checked_row(KIND_LINE, 0, 0, 1'b0, 48'h0000_0100_0000, 48'h0000_0100_0000,
                        48'h0, 48'h0),
            vertex_row(KIND_CURVE, 32767, 32767, -32768, -32768, 1'b1),
            vertex_row(KIND_CURVE, -32768, -32768, 32767, 32767, 1'b0),
            vertex_row(3'd4, -1, -1, 0, 0, 1'b0),
            vertex_row(3'd5, 3, -7, 0, 0, 1'b0),
            vertex_row(3'd6, -100, 200, 0, 0, 1'b0),
            vertex_row(KIND_MOVE, 10, 10, 0, 0, 1'b0),
            vertex_row(KIND_CURVE, 7, 3, -1, 9, 1'b1),
            scale_row(32'h0000_0000),
            vertex_row(KIND_CURVE, -32768, 32767, 32767, -32768, 1'b0),
            checked_row(KIND_LINE, 123, -456, 1'b0, 48'h0, 48'h0, 48'h0, 48'h0),
            scale_row(32'hFFFF_FFFF),
            vertex_row(KIND_CURVE, 32767, -32768, -32768, 32767, 1'b0),
            vertex_row(KIND_LINE, -32768, -32768, 0, 0, 1'b0),
            scale_row(32'h0000_0001),
            vertex_row(KIND_CURVE, -1, 1, 1, -3, 1'b0),
            checked_row(KIND_LINE, -1, -1, 1'b1, 48'h0, 48'h0,
                        48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF)
        };

        // reset
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed[r]) begin
            case (directed[r].what)
                ROW_SCALE: begin
                    wait_drain();
                    write_scale(directed[r].scale);
                end
                default: begin
                    send_vertex(directed[r].vtx);
                    if (directed[r].what == ROW_CHECKED)
                        expected_segments[expected_segments.size()-1] = directed[r].seg;
                end
            endcase
        end

        // random glyphs, one idle mix and scale per phase
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drain();
            case (p)
                0: begin
                    gap_pct = 0;
                    stall_pct = 0;
                    phase_scale = SCALE_RESET;
                end
                1: begin
                    gap_pct = 64;
                    stall_pct = 0;
                    phase_scale = $urandom;
                end
                2: begin
                    gap_pct = 0;
                    stall_pct = 64;
                    phase_scale = 32'hFFFF_FFFF;
                end
                default: begin
                    gap_pct = 20;
                    stall_pct = 20;
                    phase_scale = $urandom_range(255);
                end
            endcase
            write_scale(phase_scale);
            glyph_left = 0;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                first = (glyph_left == 0);
                if (first)
                    glyph_left = $urandom_range(9, 2);
                send_vertex(random_vertex(first));
                glyph_left--;
                // sender holds off until every segment has left
                if (i == PHASE_ITEMS / 2)
                    wait_drain();
            end
        end

        wait_drain();
        $display("covered %0d vertices and %0d segment beats under %0d scale writes",
                 vertices_sent, segments_checked, scale_writes);
        $display("idle mixes: none, sender gaps, receiver stalls, both");
        if (fail_count == 0) begin
            $display("glyph_outline_flattener test passed");
        end else begin
            $display("glyph_outline_flattener test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+src
src/glf_pkg.sv
src/glf_front.sv
src/glf_queue.sv
src/glf_scaler.sv
src/glf_back.sv
src/glyph_outline_flattener.sv
tb/tb_top.sv
